@@ src/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the positional ordered list.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_ALL  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

@@ src/plc_ram.sv @@
// ----------------------------------------------------------------------------
// plc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/positional_ordered_list.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed 32-bit values held in one RAM. Inserts and
// deletes shift entries through the RAM one per cycle; read all streams out.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  in      | in_valid/in_ready, cmd, value, position | in
//  out     | out_valid/out_ready, status, count,     | out
//          | entry_value, entry_valid, last          |
//
// Insert: entries from the position on move up one place, then the value is
// written; an append needs no shift. Delete: later entries move down one.
// Read all: one result per cycle while the result sink takes them, set by the
// RAM read port; an empty list gives a single status result.
// Reset clears the state, the count and the output valid only; the RAM holds no reset state.
// A stalled result sink holds the block at its next result; a new request is
// taken once the previous one has reached the output register.
// ----------------------------------------------------------------------------
module positional_ordered_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plc_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [plc_pkg::DATA_W-1:0] in_value,
  input  logic [plc_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [plc_pkg::COUNT_W-1:0]       out_entry_count,
  output logic signed [plc_pkg::DATA_W-1:0] out_entry_value,
  output logic                              out_entry_valid,
  output logic                              out_last
);

  localparam int IDX_W = plc_pkg::IDX_W;
  localparam int CNT_W = plc_pkg::CNT_W;
  localparam int CMP_W = plc_pkg::CMP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SHIFT, S_PUT, S_RESP, S_READ
  } state_t;

  state_t                       state_r, state_nxt;
  logic [plc_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [plc_pkg::DATA_W-1:0]   val_r, val_nxt;
  logic [plc_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [IDX_W-1:0]             dst_r, dst_nxt;
  logic [IDX_W-1:0]             rdk_r, rdk_nxt;
  logic                         ins_r, ins_nxt;
  plc_pkg::status_t             status_r, status_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [CNT_W-1:0]             out_count_r, out_count_nxt;
  logic [plc_pkg::DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                         out_evalid_r, out_evalid_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         mem_we, mem_re;
  logic [IDX_W-1:0]             mem_waddr, mem_raddr;
  logic [plc_pkg::DATA_W-1:0]   mem_wdata, mem_rdata;

  logic                         can_emit;
  logic [CMP_W-1:0]             pos_ext, cnt_ext;
  logic [IDX_W-1:0]             cnt_idx, pos_idx;
  logic [plc_pkg::POS_W-1:0]    pos_m1;
  logic                         full, empty;

  plc_ram #(
    .WIDTH (plc_pkg::DATA_W),
    .DEPTH (plc_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign can_emit = !out_valid_r || out_ready;
  assign pos_ext  = CMP_W'(pos_r);
  assign cnt_ext  = CMP_W'(cnt_r);
  assign cnt_idx  = cnt_r[IDX_W-1:0];
  assign pos_m1   = pos_r - plc_pkg::POS_W'(1);
  assign pos_idx  = pos_m1[IDX_W-1:0];
  assign full     = (cnt_r == CNT_W'(plc_pkg::CAPACITY));
  assign empty    = (cnt_r == '0);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    dst_nxt        = dst_r;
    rdk_nxt        = rdk_r;
    ins_nxt        = ins_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_value_nxt  = out_value_r;
    out_evalid_nxt = out_evalid_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = dst_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          val_nxt   = in_value;
          pos_nxt   = in_position;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = plc_pkg::ST_OK;
        state_nxt  = S_RESP;
        unique case (cmd_r)
          plc_pkg::CMD_INS_FIRST, plc_pkg::CMD_INS_LAST, plc_pkg::CMD_INS_AT: begin
            ins_nxt = 1'b1;
            if (cmd_r == plc_pkg::CMD_INS_AT &&
                (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
              status_nxt = plc_pkg::ST_BADPOS;
            end else if (full) begin
              status_nxt = plc_pkg::ST_FULL;
            end else begin
              if (cmd_r == plc_pkg::CMD_INS_FIRST) idx_nxt = '0;
              else if (cmd_r == plc_pkg::CMD_INS_LAST) idx_nxt = cnt_idx;
              else idx_nxt = pos_idx;
              if (idx_nxt == cnt_idx) begin
                // append: no shift
                mem_we    = 1'b1;
                mem_waddr = cnt_idx;
                mem_wdata = val_r;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_idx - IDX_W'(1);
                dst_nxt   = cnt_idx;
                state_nxt = S_SHIFT;
              end
            end
          end
          plc_pkg::CMD_DEL_FIRST, plc_pkg::CMD_DEL_LAST, plc_pkg::CMD_DEL_AT: begin
            ins_nxt = 1'b0;
            if (empty) begin
              status_nxt = plc_pkg::ST_EMPTY;
            end else if (cmd_r == plc_pkg::CMD_DEL_AT &&
                         (pos_ext == '0 || pos_ext > cnt_ext)) begin
              status_nxt = plc_pkg::ST_BADPOS;
            end else begin
              if (cmd_r == plc_pkg::CMD_DEL_FIRST) idx_nxt = '0;
              else if (cmd_r == plc_pkg::CMD_DEL_LAST) idx_nxt = IDX_W'(cnt_r - CNT_W'(1));
              else idx_nxt = pos_idx;
              if (CNT_W'(idx_nxt) + CNT_W'(1) == cnt_r) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_nxt + IDX_W'(1);
                dst_nxt   = idx_nxt;
                state_nxt = S_SHIFT;
              end
            end
          end
          plc_pkg::CMD_READ_ALL: begin
            if (!empty) begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              rdk_nxt   = '0;
              state_nxt = S_READ;
            end
          end
          default: ;
        endcase
      end

      S_SHIFT: begin
        // rdata holds the neighbor of dst_r read last cycle
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata;
        if (ins_r) begin
          if (dst_r == idx_r + IDX_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = dst_r - IDX_W'(2);
            dst_nxt   = dst_r - IDX_W'(1);
          end
        end else begin
          if (CNT_W'(dst_r) + CNT_W'(2) == cnt_r) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = dst_r + IDX_W'(2);
            dst_nxt   = dst_r + IDX_W'(1);
          end
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = cnt_r;
          out_value_nxt  = '0;
          out_evalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_READ: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = plc_pkg::ST_OK;
          out_count_nxt  = cnt_r;
          out_value_nxt  = mem_rdata;
          out_evalid_nxt = 1'b1;
          out_last_nxt   = (CNT_W'(rdk_r) + CNT_W'(1) == cnt_r);
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rdk_r + IDX_W'(1);
            rdk_nxt   = rdk_r + IDX_W'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    dst_r        <= dst_nxt;
    rdk_r        <= rdk_nxt;
    ins_r        <= ins_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_value_r  <= out_value_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = plc_pkg::COUNT_W'(out_count_r);
  assign out_entry_value = out_value_r;
  assign out_entry_valid = out_evalid_r;
  assign out_last        = out_last_r;

  // count stays within bounds
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(plc_pkg::CAPACITY))
    else $error("entry count above capacity");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  // read-out entries always carry ok status
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> (out_status == plc_pkg::ST_OK))
    else $error("read entry with error status");

  // count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) ||
                      cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("count jumped");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional ordered list. A queue tracks the
// list contents and predicts every result: status, count and read-out
// entries. Directed edge requests come first, then a full-list sweep and a
// random mix, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CMD_W    = plc_pkg::CMD_W;
  localparam int DATA_W   = plc_pkg::DATA_W;
  localparam int POS_W    = plc_pkg::POS_W;
  localparam int COUNT_W  = plc_pkg::COUNT_W;
  localparam int CAPACITY = plc_pkg::CAPACITY;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    plc_pkg::status_t         status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] value;
    logic                     valid;
    logic                     last;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic [COUNT_W-1:0]       out_entry_count;
  logic signed [DATA_W-1:0] out_entry_value;
  logic                     out_entry_valid;
  logic                     out_last;

  logic signed [DATA_W-1:0] list_contents[$];
  list_result_t             pending_results[$];
  list_result_t             head_result;

  int error_count = 0;
  int request_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int sink_phase = 0;
  int sink_mode = 0;

  positional_ordered_list i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_entry_value (out_entry_value),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: stall mode is picked anew whenever the phase counter runs out, mode 0 never stalls
  always @(posedge clk) begin
    if (sink_phase == 0) begin
      sink_mode  <= $urandom_range(0, 3);
      sink_phase <= $urandom_range(20, 80);
    end else begin
      sink_phase <= sink_phase - 1;
    end
    case (sink_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_count <= result_count + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d count %0d value %0d",
               out_status, out_entry_count, out_entry_value);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, out_status);
          error_count++;
        end
        if (out_entry_count !== head_result.count) begin
          $error("entry_count: expected %0d, got %0d", head_result.count,
                 out_entry_count);
          error_count++;
        end
        if (out_entry_value !== head_result.value) begin
          $error("entry_value: expected %0d, got %0d", head_result.value,
                 out_entry_value);
          error_count++;
        end
        if (out_entry_valid !== head_result.valid) begin
          $error("entry_valid: expected %0d, got %0d", head_result.valid,
                 out_entry_valid);
          error_count++;
        end
        if (out_last !== head_result.last) begin
          $error("last: expected %0d, got %0d", head_result.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Update the list copy for one accepted request and queue its results.
  task automatic apply_list_request(logic [CMD_W-1:0] cmd,
                                    logic signed [DATA_W-1:0] value,
                                    logic [POS_W-1:0] pos);
    plc_pkg::status_t st;
    int               held;
    list_result_t     r;
    st   = plc_pkg::ST_OK;
    held = list_contents.size();
    case (cmd)
      plc_pkg::CMD_INS_FIRST, plc_pkg::CMD_INS_LAST: begin
        if (held >= CAPACITY) st = plc_pkg::ST_FULL;
        else if (cmd == plc_pkg::CMD_INS_FIRST) list_contents.push_front(value);
        else list_contents.push_back(value);
      end
      plc_pkg::CMD_INS_AT: begin
        // position is checked before the full test
        if (pos < 1 || pos > held + 1) st = plc_pkg::ST_BADPOS;
        else if (held >= CAPACITY) st = plc_pkg::ST_FULL;
        else list_contents.insert(pos - 1, value);
      end
      plc_pkg::CMD_DEL_FIRST, plc_pkg::CMD_DEL_LAST: begin
        if (held == 0) st = plc_pkg::ST_EMPTY;
        else if (cmd == plc_pkg::CMD_DEL_FIRST) void'(list_contents.pop_front());
        else void'(list_contents.pop_back());
      end
      plc_pkg::CMD_DEL_AT: begin
        // empty is checked before position
        if (held == 0) st = plc_pkg::ST_EMPTY;
        else if (pos < 1 || pos > held) st = plc_pkg::ST_BADPOS;
        else list_contents.delete(pos - 1);
      end
      plc_pkg::CMD_READ_ALL: begin
        if (held != 0) begin
          for (int i = 0; i < held; i++) begin
            r = '{plc_pkg::ST_OK, held[COUNT_W-1:0], list_contents[i], 1'b1,
                  i == held - 1};
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r = '{st, COUNT_W'(list_contents.size()), '0, 1'b0, 1'b1};
    pending_results.push_back(r);
  endtask

  task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value,
                              logic [POS_W-1:0] pos);
    int gap;
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_value    <= value;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    apply_list_request(cmd, value, pos);
    request_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // sender holds off until the block has returned every queued result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // mostly a legal position for the current list, now and then anything
  function automatic logic [POS_W-1:0] pick_position(int max_pos);
    if (max_pos < 1 || $urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, 127));
    return POS_W'($urandom_range(1, max_pos));
  endfunction

  task automatic test_empty_list();
    send_request(plc_pkg::CMD_DEL_FIRST, 0, 0);
    send_request(plc_pkg::CMD_DEL_LAST, 0, 0);
    send_request(plc_pkg::CMD_DEL_AT, 0, 0);
    send_request(plc_pkg::CMD_DEL_AT, 0, 1);
    send_request(plc_pkg::CMD_READ_ALL, 0, 0);
    send_request(CMD_UNUSED, 32'sh1234_5678, 7'd127);
  endtask

  task automatic test_insert_edges();
    send_request(plc_pkg::CMD_INS_AT, 5, 0);
    send_request(plc_pkg::CMD_INS_AT, 5, 2);
    send_request(plc_pkg::CMD_INS_FIRST, 32'sh7fff_ffff, 0);
    send_request(plc_pkg::CMD_INS_LAST, 32'sh8000_0000, 0);
    send_request(plc_pkg::CMD_INS_AT, 0, 1);
    send_request(plc_pkg::CMD_INS_AT, -1, 4);
    send_request(plc_pkg::CMD_INS_AT, 32'sh5555_5555, 2);
    send_request(plc_pkg::CMD_INS_AT, 32'shaaaa_aaaa, 7'd127);
    send_request(plc_pkg::CMD_READ_ALL, 0, 0);
  endtask

  task automatic test_delete_edges();
    send_request(plc_pkg::CMD_DEL_AT, 0, 0);
    send_request(plc_pkg::CMD_DEL_AT, 0, 6);
    send_request(plc_pkg::CMD_DEL_AT, 0, 3);
    send_request(plc_pkg::CMD_DEL_FIRST, 0, 0);
    send_request(plc_pkg::CMD_DEL_LAST, 0, 0);
    send_request(plc_pkg::CMD_READ_ALL, 0, 0);
    send_request(CMD_UNUSED, 0, 0);
  endtask

  // fill to capacity with random inserts, push past it, then empty again
  task automatic test_full_list_sweep();
    logic [CMD_W-1:0] cmd;
    while (list_contents.size() < CAPACITY) begin
      cmd = CMD_W'($urandom_range(plc_pkg::CMD_INS_FIRST, plc_pkg::CMD_INS_AT));
      send_request(cmd, pick_value(), pick_position(list_contents.size() + 1));
    end
    send_request(plc_pkg::CMD_INS_FIRST, pick_value(), 0);
    send_request(plc_pkg::CMD_INS_LAST, pick_value(), 0);
    send_request(plc_pkg::CMD_INS_AT, pick_value(), POS_W'(CAPACITY + 1));
    send_request(plc_pkg::CMD_INS_AT, pick_value(), POS_W'(CAPACITY + 2));
    send_request(plc_pkg::CMD_INS_AT, pick_value(), POS_W'($urandom_range(1, CAPACITY)));
    send_request(plc_pkg::CMD_READ_ALL, 0, 0);
    while (list_contents.size() > 0) begin
      cmd = CMD_W'($urandom_range(plc_pkg::CMD_DEL_FIRST, plc_pkg::CMD_DEL_AT));
      send_request(cmd, pick_value(), pick_position(list_contents.size()));
      if ($urandom_range(0, 15) == 0) send_request(plc_pkg::CMD_READ_ALL, 0, 0);
    end
    send_request(plc_pkg::CMD_DEL_AT, 0, POS_W'($urandom_range(0, 127)));
  endtask

  task automatic test_random_mix(int n_requests);
    int               held;
    int               roll;
    int               ins_weight;
    logic [CMD_W-1:0] cmd;
    for (int k = 0; k < n_requests; k++) begin
      held       = list_contents.size();
      roll       = $urandom_range(0, 99);
      ins_weight = held < 8 ? 70 : (held > 26 ? 30 : 50);
      if (roll < 5) begin
        send_request(CMD_W'($urandom_range(0, 7)), $urandom,
                     POS_W'($urandom_range(0, 127)));
      end else if (roll < 12) begin
        send_request(plc_pkg::CMD_READ_ALL, $urandom, POS_W'($urandom_range(0, 127)));
      end else if ($urandom_range(0, 99) < ins_weight) begin
        cmd = CMD_W'($urandom_range(plc_pkg::CMD_INS_FIRST, plc_pkg::CMD_INS_AT));
        send_request(cmd, pick_value(), pick_position(held + 1));
      end else begin
        cmd = CMD_W'($urandom_range(plc_pkg::CMD_DEL_FIRST, plc_pkg::CMD_DEL_AT));
        send_request(cmd, $urandom, pick_position(held));
      end
      if (k == n_requests / 2) drain_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_insert_edges();
    test_delete_edges();
    drain_results();
    test_full_list_sweep();
    drain_results();
    test_random_mix(100);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests and checked %0d results: empty and full list limits,",
             request_count, result_count);
    $display("bad positions, unused command, read-out streams and a random mix.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
